// ===== hdl/lmat_pkg.sv =====
`timescale 1ns / 1ps

package lmat_pkg;

    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int TS_W        = 48;
    localparam int LEVEL_W     = 10;
    localparam int CODE_W      = 16;
    localparam int LAT_W       = 49;
    localparam int IV_W        = 16;
    localparam logic [IV_W-1:0] IV_RESET = 16'd64;

    typedef enum logic [1:0] {
        CMD_ISSUE  = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_END    = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DELTA,
        S_CALC,
        S_READ
    } t_state;

    typedef struct packed {
        logic [1:0]         command;
        logic [TS_W-1:0]    timestamp;
        logic [LEVEL_W-1:0] level_count;
        logic [CODE_W-1:0]  code_index;
    } t_in_beat;

    typedef struct packed {
        logic [LAT_W-1:0]  latency_half;
        logic [CODE_W-1:0] done_code_index;
        logic              last;
        logic              overflow;
    } t_out_beat;

    typedef struct packed {
        logic [TS_W-1:0]   qtime;
        logic [CODE_W-1:0] qcode;
    } t_qentry;

endpackage

// ===== hdl/lmat_in_if.sv =====
`timescale 1ns / 1ps

interface lmat_in_if import lmat_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/lmat_out_if.sv =====
`timescale 1ns / 1ps

interface lmat_out_if import lmat_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/issue_to_completion_latency_matcher_unit.sv =====
`timescale 1ns / 1ps

// Issue-to-completion latency matcher. Issue beats push {time, code} into a
// QUEUE_DEPTH-entry FIFO held in a synchronous RAM; a sample beat pops the
// oldest entries while more are outstanding than the sampled level, at most
// 64 per sample, and emits one latency estimate (half time units) per pop,
// with last set on the final one. After an end-of-issues beat, samples drop
// the excess entries at once and emit nothing. Each emitting pop passes
// through S_DELTA for the delta subtract and S_CALC for the latency
// correction, where it waits out any output stall, and every pop but the
// last also passes through S_READ to re-read the RAM at the new head. The
// input is held off until the last result of a sample is loaded.
// The output register lets the input accept the next beat while the last
// result of a sample is still waiting. A full FIFO drops the issue and sets
// the sticky overflow flag reported with every result.
module issue_to_completion_latency_matcher_unit import lmat_pkg::*; #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lmat_in_if.sink           i_in,
    lmat_out_if.source        o_out,
    input  logic              i_cfg_we,
    input  logic [IV_W-1:0]   i_cfg_wdata
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int OW = $clog2(QUEUE_DEPTH + 1);
    localparam int CW = (OW > LEVEL_W) ? OW : LEVEL_W;
    localparam int SW = OW + 1;
    localparam logic [PW-1:0] HEAD_LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [OW-1:0] DEPTH_C   = OW'(QUEUE_DEPTH);
    localparam logic [SW-1:0] DEPTH_S   = SW'(QUEUE_DEPTH);

    t_qentry r_mem [QUEUE_DEPTH];
    t_qentry r_rd;

    t_state r_state, n_state;

    logic [PW-1:0]      r_head, r_tail;
    logic [OW-1:0]      r_outst;
    logic               r_closed, r_ovf;
    logic [IV_W-1:0]    r_iv;
    logic [TS_W-1:0]    r_ts;
    logic [LEVEL_W-1:0] r_level;
    logic [CNT_W-1:0]   r_cnt;
    logic [TS_W-1:0]    r_delta;
    logic [CODE_W-1:0]  r_code;
    logic               r_last;
    logic               r_ovalid;
    t_out_beat          r_obeat;

    logic               in_fire, in_ready, out_load;
    logic               pop_needed, still_needed;
    logic [CW-1:0]      outst_ext, level_ext, outst_dec_ext, drop_n;
    logic [SW-1:0]      head_sum;
    logic [PW-1:0]      head_skip;
    logic [LAT_W-1:0]   lat;
    logic [LAT_W-1:0]   delta2;

    assign in_fire = i_in.valid && in_ready;

    assign outst_ext     = CW'(r_outst);
    assign level_ext     = CW'(i_in.data.level_count);
    assign pop_needed    = outst_ext > level_ext;
    assign drop_n        = outst_ext - level_ext;
    assign head_sum      = SW'(r_head) + SW'(drop_n[OW-1:0]);
    assign head_skip     = (head_sum >= DEPTH_S) ? PW'(head_sum - DEPTH_S) : PW'(head_sum);
    assign outst_dec_ext = CW'(r_outst - OW'(1));
    assign still_needed  = outst_dec_ext > CW'(r_level);

    // 2*delta - interval only when delta exceeds interval, so no wrap in 49 bits
    assign delta2 = {r_delta, 1'b0};
    assign lat    = (r_delta > TS_W'(r_iv)) ? delta2 - LAT_W'(r_iv) : LAT_W'(r_delta);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire && i_in.data.command == CMD_SAMPLE && !r_closed && pop_needed)
                    n_state = S_DELTA;
            end
            S_DELTA: n_state = S_CALC;
            S_CALC: begin
                if (out_load)
                    n_state = r_last ? S_IDLE : S_READ;
            end
            S_READ: n_state = S_DELTA;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            S_IDLE: in_ready = 1'b1;
            S_CALC: out_load = !r_ovalid || o_out.ready;
            S_DELTA, S_READ: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_head];
        if (in_fire && i_in.data.command == CMD_ISSUE && !r_closed && r_outst < DEPTH_C)
            r_mem[r_tail] <= '{qtime: i_in.data.timestamp, qcode: i_in.data.code_index};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_outst  <= '0;
            r_closed <= 1'b0;
            r_ovf    <= 1'b0;
            r_iv     <= IV_RESET;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we)
                r_iv <= i_cfg_wdata;

            if (out_load)
                r_ovalid <= 1'b1;
            else if (r_ovalid && o_out.ready)
                r_ovalid <= 1'b0;

            if (in_fire) begin
                priority if (i_in.data.command == CMD_ISSUE) begin
                    if (!r_closed) begin
                        if (r_outst >= DEPTH_C) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_tail  <= (r_tail == HEAD_LAST) ? '0 : r_tail + PW'(1);
                            r_outst <= r_outst + OW'(1);
                        end
                    end
                end else if (i_in.data.command == CMD_SAMPLE) begin
                    r_ts    <= i_in.data.timestamp;
                    r_level <= i_in.data.level_count;
                    r_cnt   <= '0;
                    // closed: drop the excess at once, nothing is emitted
                    if (r_closed && pop_needed) begin
                        r_head  <= head_skip;
                        r_outst <= r_outst - drop_n[OW-1:0];
                    end
                end else if (i_in.data.command == CMD_END) begin
                    r_closed <= 1'b1;
                end else begin
                end
            end

            if (r_state == S_DELTA) begin
                r_delta <= (r_ts >= r_rd.qtime) ? r_ts - r_rd.qtime : '0;
                r_code  <= r_rd.qcode;
                r_last  <= !still_needed || (r_cnt == CNT_W'(MAX_RESULTS - 1));
                r_cnt   <= r_cnt + CNT_W'(1);
                r_head  <= (r_head == HEAD_LAST) ? '0 : r_head + PW'(1);
                r_outst <= r_outst - OW'(1);
            end

            if (out_load) begin
                r_obeat  <= '{latency_half: lat, done_code_index: r_code,
                              last: r_last, overflow: r_ovf};
            end
        end
    end

    assign i_in.ready  = in_ready;
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_obeat;

endmodule
